### sv/gdd_pkg.sv
// gdd_pkg: shared widths, constants, control struct and month table
`timescale 1ns / 1ps

package gdd_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int CountW = 22;
  localparam int OrdW   = 23;  // ordinal day number of a 14-bit year
  localparam int Q100W  = 8;   // year / 100 for a 14-bit year
  localparam int DbmW   = 9;   // days before a month, at most 366

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // floor(y / 100) == (y * Recip100) >> Recip100Shift, exact for 14-bit y
  localparam int Recip100W     = 13;
  localparam int Recip100Shift = 19;
  localparam logic [Recip100W-1:0] Recip100 = 13'd5243;
  localparam logic [8:0]           DaysPerYear = 9'd365;
  localparam logic [6:0]           YearsPerCentury = 7'd100;

  localparam logic [MonthW-1:0] LastMonthIdx = 4'd13;

  // days in the months before month m, normal year and leap year
  localparam logic [DbmW-1:0] DaysBefore [2][14] = '{
    '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
    '{9'd0, 9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
  };

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // load the input beat
    logic mul;       // form year*365 and year/100
    logic ord;       // form both ordinal day numbers
    logic load_out;  // compare, subtract and load the result register
  } gdd_cmd_t;

  function automatic logic [DbmW-1:0] days_before(input logic leap,
                                                  input logic [MonthW-1:0] m);
    logic [MonthW-1:0] idx;
    idx = (m > LastMonthIdx) ? LastMonthIdx : m;
    return DaysBefore[leap][idx];
  endfunction

endpackage

### sv/gdd_intf.sv
// gdd_intf: valid/ready channel interfaces for date pairs and day counts
`timescale 1ns / 1ps

interface gdd_in_if;
  logic                          valid;
  logic                          ready;
  logic [gdd_pkg::DayW-1:0]      start_day;
  logic [gdd_pkg::MonthW-1:0]    start_month;
  logic [gdd_pkg::YearW-1:0]     start_year;
  logic [gdd_pkg::DayW-1:0]      end_day;
  logic [gdd_pkg::MonthW-1:0]    end_month;
  logic [gdd_pkg::YearW-1:0]     end_year;

  modport source (output valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, input ready);
  modport sink   (input valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, output ready);
endinterface

interface gdd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gdd_pkg::CountW-1:0]    day_count;
  logic                          end_before_start;

  modport source (output valid, day_count, end_before_start, input ready);
  modport sink   (input valid, day_count, end_before_start, output ready);
endinterface

### sv/gdd_ctrl.sv
// gdd_ctrl: sequencer for one date pair and the output valid flag
`timescale 1ns / 1ps

module gdd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output gdd_pkg::gdd_cmd_t cmd_o
);
  import gdd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StOrd  = 2'd2;
  localparam logic [1:0] StDiff = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StOrd;
      end
      StOrd: begin
        cmd_o.ord = 1'b1;
        state_d   = StDiff;
      end
      StDiff: begin
        // wait here while the previous result is still unclaimed
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == StMul))
    else $error("capture did not start the multiply step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |=> (state_q == StOrd) ##1 (state_q == StDiff))
    else $error("step sequence broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while full");

endmodule

### sv/gdd_dp.sv
// gdd_dp: ordinal day datapath for both dates and the difference register
`timescale 1ns / 1ps

module gdd_dp (
  input  logic                           clk_i,
  input  gdd_pkg::gdd_cmd_t              cmd_i,
  input  logic [gdd_pkg::DayW-1:0]       start_day_i,
  input  logic [gdd_pkg::MonthW-1:0]     start_month_i,
  input  logic [gdd_pkg::YearW-1:0]      start_year_i,
  input  logic [gdd_pkg::DayW-1:0]       end_day_i,
  input  logic [gdd_pkg::MonthW-1:0]     end_month_i,
  input  logic [gdd_pkg::YearW-1:0]      end_year_i,
  output logic [gdd_pkg::CountW-1:0]     day_count_o,
  output logic                           end_before_start_o
);
  import gdd_pkg::*;

  localparam int ProdW = YearW + Recip100W;

  // lane 0 is the start date, lane 1 the end date
  logic [DayW-1:0]   day_q   [2];
  logic [MonthW-1:0] month_q [2];
  logic [YearW-1:0]  year_q  [2];
  logic [Q100W-1:0]  q100_q  [2];
  logic [OrdW-1:0]   y365_q  [2];
  logic [OrdW-1:0]   ord_q   [2];

  logic [Q100W-1:0]  q100_d  [2];
  logic [OrdW-1:0]   y365_d  [2];
  logic [OrdW-1:0]   ord_d   [2];

  logic [CountW-1:0] day_count_q, day_count_d;
  logic              ebs_q, ebs_d;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [ProdW-1:0] prod;
    logic [YearW:0]   cent;
    logic [YearW:0]   rem_full;
    logic [6:0]       r100;
    logic             leap;
    logic [Q100W-1:0] c100;
    logic [Q100W-3:0] c400;
    logic [YearW-2:0] c4;

    always_comb begin
      prod      = ProdW'(year_q[l]) * ProdW'(Recip100);
      q100_d[l] = Q100W'(prod >> Recip100Shift);
      y365_d[l] = OrdW'(year_q[l]) * OrdW'(DaysPerYear);
    end

    always_comb begin
      cent     = (YearW+1)'(q100_q[l]) * (YearW+1)'(YearsPerCentury);
      rem_full = (YearW+1)'(year_q[l]) - cent;
      r100     = rem_full[6:0];
      // divisible by 4 and either not by 100 or by 400
      leap     = (year_q[l][1:0] == 2'b00) && ((r100 != 7'd0) || (q100_q[l][1:0] == 2'b00));
      c100     = q100_q[l] + Q100W'(r100 != 7'd0);
      c400     = (Q100W-2)'((9'(c100) + 9'd3) >> 2);
      c4       = (YearW-1)'(((YearW+1)'(year_q[l]) + (YearW+1)'(3)) >> 2);
      ord_d[l] = y365_q[l] + OrdW'(c4) - OrdW'(c100) + OrdW'(c400)
               + OrdW'(days_before(leap, month_q[l])) + OrdW'(day_q[l]);
    end
  end

  always_comb begin
    logic [OrdW-1:0] diff;
    diff        = ord_q[1] - ord_q[0];
    day_count_d = '0;
    ebs_d       = 1'b0;
    if (ord_q[1] < ord_q[0]) begin
      ebs_d = 1'b1;
    end else if (diff > OrdW'(CountMax)) begin
      day_count_d = CountMax;
    end else begin
      day_count_d = diff[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      day_q[0]   <= start_day_i;
      month_q[0] <= start_month_i;
      year_q[0]  <= start_year_i;
      day_q[1]   <= end_day_i;
      month_q[1] <= end_month_i;
      year_q[1]  <= end_year_i;
    end
    if (cmd_i.mul) begin
      q100_q <= q100_d;
      y365_q <= y365_d;
    end
    if (cmd_i.ord) begin
      ord_q <= ord_d;
    end
    if (cmd_i.load_out) begin
      day_count_q <= day_count_d;
      ebs_q       <= ebs_d;
    end
  end

  assign day_count_o        = day_count_q;
  assign end_before_start_o = ebs_q;

endmodule

### sv/gregorian_date_difference_top.sv
// gregorian_date_difference_top: days between two Gregorian dates
`timescale 1ns / 1ps

// usage
// - in_i carries one date pair per beat: start and end day, month, year
// - out_o carries one result per input beat: day_count and end_before_start
// - day_count is the end ordinal minus the start ordinal, saturated to the
//   22-bit maximum; when the end date lies before the start date the count
//   is 0 and end_before_start is 1
// - each pair walks the capture, year multiply, ordinal sum and difference
//   steps of the sequencer in turn; a new pair is taken only after the
//   difference step, so at most one pair is in work at a time
// - in_i.ready is high only while the sequencer is idle; it rises again in
//   the cycle after the result register is loaded, so a new pair can be
//   taken while the previous result still waits on out_o
// - when out_o stalls, the block finishes the next pair and holds it in the
//   difference step until the result register frees up; nothing is dropped
// - reset (async, active low) returns the sequencer to idle and clears the
//   output valid; there is no stored state beyond the item in flight

module gregorian_date_difference_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdd_in_if.sink    in_i,
  gdd_out_if.source out_o
);
  import gdd_pkg::*;

  gdd_cmd_t cmd;

  // sequencer: handshakes and step commands
  gdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // datapath: ordinal day numbers and their difference
  gdd_dp u_dp (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .start_day_i        (in_i.start_day),
    .start_month_i      (in_i.start_month),
    .start_year_i       (in_i.start_year),
    .end_day_i          (in_i.end_day),
    .end_month_i        (in_i.end_month),
    .end_year_i         (in_i.end_year),
    .day_count_o        (out_o.day_count),
    .end_before_start_o (out_o.end_before_start)
  );

  // the sequencer is busy after an accept, so no second pair is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second pair taken while busy");

  // once the pair reaches the difference step it is loaded or waits on a full result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> ##3 (cmd.load_out || out_o.valid))
    else $error("result sequencing broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.end_before_start) |-> (out_o.day_count == '0))
    else $error("nonzero count with end before start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !cmd.load_out ##1 !cmd.load_out)
    else $error("result loaded too early");

endmodule

### test/tb_top.sv
// tb_top: self-checking testbench for the gregorian date difference block
`timescale 1ns / 1ps

module tb_top;
  import gdd_pkg::*;

  // one date pair as it travels on the input channel
  typedef struct packed {
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [YearW-1:0]  start_year;
    logic [DayW-1:0]   end_day;
    logic [MonthW-1:0] end_month;
    logic [YearW-1:0]  end_year;
  } date_pair_t;

  // one day count as it travels on the output channel
  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              end_before_start;
  } day_result_t;

  logic clk_i;
  logic rst_ni;

  gdd_in_if  in_if ();
  gdd_out_if out_if ();

  gregorian_date_difference_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // day counts still owed by the block, oldest first
  day_result_t pending_counts[$];

  // idling knobs, percent per cycle
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // receiver hold-off request and its running count
  int unsigned hold_len  = 0;
  int unsigned hold_left = 0;

  int unsigned n_errors    = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_reversed  = 0;
  int unsigned n_saturated = 0;

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // calendar arithmetic of the predictor
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // days in the months ahead of month m; m is already clamped to 0..13
  function automatic int unsigned month_offset(bit leap, int unsigned m);
    int unsigned base;
    case (m)
      0, 1:    base = 0;
      2:       base = 31;
      3:       base = 59;
      4:       base = 90;
      5:       base = 120;
      6:       base = 151;
      7:       base = 181;
      8:       base = 212;
      9:       base = 243;
      10:      base = 273;
      11:      base = 304;
      12:      base = 334;
      default: base = 365;
    endcase
    // february 29 pushes every later month by one
    return base + ((leap && m >= 3) ? 1 : 0);
  endfunction

  // day number counted from the start of year zero
  function automatic longint unsigned day_ordinal(logic [DayW-1:0] d,
                                                  logic [MonthW-1:0] m,
                                                  logic [YearW-1:0] y);
    int unsigned yy;
    int unsigned mm;
    int unsigned leaps;
    yy = y;
    // months past december count the whole year, like month thirteen
    mm = (m > 13) ? 13 : m;
    // leap years in 0 .. yy-1, year zero included
    leaps = (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
    return longint'(365 * yy + leaps + month_offset(leap_year(yy), mm) + d);
  endfunction

  function automatic day_result_t predict_difference(date_pair_t p);
    longint unsigned from_day;
    longint unsigned to_day;
    day_result_t     r;
    from_day = day_ordinal(p.start_day, p.start_month, p.start_year);
    to_day   = day_ordinal(p.end_day, p.end_month, p.end_year);
    if (to_day < from_day) begin
      // reversed dates give zero and the flag
      r.day_count        = '0;
      r.end_before_start = 1'b1;
    end else if (to_day - from_day > CountMax) begin
      // only years past 9999 can get here
      r.day_count        = CountMax;
      r.end_before_start = 1'b0;
    end else begin
      r.day_count        = CountW'(to_day - from_day);
      r.end_before_start = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic date_pair_t make_pair(int unsigned sd, int unsigned sm,
                                           int unsigned sy, int unsigned ed,
                                           int unsigned em, int unsigned ey);
    date_pair_t p;
    p.start_day   = DayW'(sd);
    p.start_month = MonthW'(sm);
    p.start_year  = YearW'(sy);
    p.end_day     = DayW'(ed);
    p.end_month   = MonthW'(em);
    p.end_year    = YearW'(ey);
    return p;
  endfunction

  // a legal day of month m in year y
  function automatic int unsigned random_day(int unsigned y, int unsigned m);
    bit leap;
    leap = leap_year(y);
    return $urandom_range(1, month_offset(leap, m + 1) - month_offset(leap, m));
  endfunction

  // a well-formed date, with the year ends and centuries weighted up
  function automatic void random_date(output int unsigned d,
                                      output int unsigned m,
                                      output int unsigned y);
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(1, 3);
      1:       y = $urandom_range(9996, 9999);
      2:       y = 100 * $urandom_range(1, 99);
      default: y = $urandom_range(1, 9999);
    endcase
    m = $urandom_range(1, 12);
    d = random_day(y, m);
  endfunction

  // one beat on the input channel; valid stays up after the handshake so
  // that back-to-back beats never lower it for a step
  task automatic send_pair(input date_pair_t p);
    day_result_t r;
    in_if.valid       <= 1'b1;
    in_if.start_day   <= p.start_day;
    in_if.start_month <= p.start_month;
    in_if.start_year  <= p.start_year;
    in_if.end_day     <= p.end_day;
    in_if.end_month   <= p.end_month;
    in_if.end_year    <= p.end_year;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = predict_difference(p);
    pending_counts.push_back(r);
    n_sent++;
    if (r.end_before_start) n_reversed++;
    if (!r.end_before_start && r.day_count == CountMax) n_saturated++;
  endtask

  // random sender gap after a beat, one idle cycle at a time
  task automatic sender_gap();
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // sender stands still until every owed count has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned gap, int unsigned stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked pairs: calendar edges, leap rule, unchecked fields, saturation
  task automatic test_directed();
    date_pair_t list[$];
    set_idling(0, 0);
    list.push_back(make_pair(1, 1, 1, 1, 1, 1));            // equal dates
    list.push_back(make_pair(1, 1, 1, 31, 12, 9999));       // full nominal span
    list.push_back(make_pair(31, 12, 9999, 1, 1, 1));       // fully reversed
    list.push_back(make_pair(2, 1, 2024, 1, 1, 2024));      // reversed by a day
    list.push_back(make_pair(28, 2, 2000, 1, 3, 2000));     // leap by 400
    list.push_back(make_pair(28, 2, 1900, 1, 3, 1900));     // century, no leap
    list.push_back(make_pair(28, 2, 2024, 1, 3, 2024));     // leap by 4
    list.push_back(make_pair(28, 2, 2023, 1, 3, 2023));     // plain year
    list.push_back(make_pair(31, 12, 1999, 1, 1, 2000));    // across a year
    list.push_back(make_pair(1, 1, 1600, 1, 1, 2000));      // whole 400-year cycle
    list.push_back(make_pair(0, 1, 2020, 31, 1, 2020));     // day zero
    list.push_back(make_pair(1, 3, 2021, 31, 2, 2021));     // day past month end
    list.push_back(make_pair(1, 0, 2020, 1, 1, 2020));      // month zero
    list.push_back(make_pair(1, 13, 2020, 1, 1, 2021));     // month thirteen
    list.push_back(make_pair(1, 15, 2019, 1, 14, 2019));    // months above twelve
    list.push_back(make_pair(1, 1, 0, 1, 1, 1));            // year zero is leap
    list.push_back(make_pair(0, 0, 0, 31, 12, 9999));       // all-zero start
    list.push_back(make_pair(0, 0, 0, 31, 15, 16383));      // saturates
    list.push_back(make_pair(0, 0, 4000, 31, 15, 16383));   // saturates
    list.push_back(make_pair(31, 15, 16383, 0, 0, 0));      // reversed, max fields
    list.push_back(make_pair(31, 15, 16383, 31, 15, 16383)); // equal, all ones
    foreach (list[i]) send_pair(list[i]);
    wait_drained();
  endtask

  // well-formed pairs, mostly close together so both orders are common
  task automatic test_random_dates(int unsigned n_pairs);
    int unsigned sd, sm, sy, ed, em, ey;
    int          yy;
    for (int i = 0; i < n_pairs; i++) begin
      // four idling phases in turn
      case ((i * 4) / n_pairs)
        0:       set_idling(0, 0);
        1:       set_idling(50, 0);
        2:       set_idling(0, 50);
        default: set_idling(23, 23);
      endcase
      random_date(sd, sm, sy);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          ey = sy;
          em = $urandom_range(1, 12);
          ed = random_day(ey, em);
        end
        4, 5: begin
          yy = int'(sy) + $urandom_range(0, 6) - 3;
          ey = (yy < 1) ? 1 : (yy > 9999) ? 9999 : yy;
          em = $urandom_range(1, 12);
          ed = random_day(ey, em);
        end
        6: begin
          ed = sd;
          em = sm;
          ey = sy;
        end
        default: random_date(ed, em, ey);
      endcase
      send_pair(make_pair(sd, sm, sy, ed, em, ey));
      sender_gap();
    end
    wait_drained();
  endtask

  // every field over its full bit width: bad days, months, huge years
  task automatic test_raw_fields(int unsigned n_pairs);
    date_pair_t p;
    set_idling(23, 23);
    for (int i = 0; i < n_pairs; i++) begin
      p.start_day   = DayW'($urandom);
      p.start_month = MonthW'($urandom);
      p.start_year  = YearW'($urandom);
      p.end_day     = DayW'($urandom);
      p.end_month   = MonthW'($urandom);
      p.end_year    = YearW'($urandom);
      send_pair(p);
      sender_gap();
    end
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering beats, so the
  // block fills and drops in_i.ready; then a full drain and a mixed tail
  task automatic test_backpressure();
    int unsigned sd, sm, sy, ed, em, ey;
    set_idling(0, 0);
    hold_len = 400;
    for (int i = 0; i < 30; i++) begin
      random_date(sd, sm, sy);
      random_date(ed, em, ey);
      send_pair(make_pair(sd, sm, sy, ed, em, ey));
    end
    wait_drained();
    set_idling(23, 23);
    for (int i = 0; i < 30; i++) begin
      random_date(sd, sm, sy);
      random_date(ed, em, ey);
      send_pair(make_pair(sd, sm, sy, ed, em, ey));
      sender_gap();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus the counted hold-off
  // ---------------------------------------------------------------------------

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each result beat against the oldest owed count
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    day_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("result beat with no date pair waiting, count %0d",
                                  out_if.day_count));
      end else begin
        want = pending_counts.pop_front();
        n_checked++;
        if (out_if.day_count !== want.day_count)
          report_mismatch($sformatf("day_count %0d, expected %0d",
                                    out_if.day_count, want.day_count));
        if (out_if.end_before_start !== want.end_before_start)
          report_mismatch($sformatf("end_before_start %0b, expected %0b",
                                    out_if.end_before_start, want.end_before_start));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // every input known from time zero
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.start_day   = '0;
    in_if.start_month = '0;
    in_if.start_year  = '0;
    in_if.end_day     = '0;
    in_if.end_month   = '0;
    in_if.end_year    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_dates(1300);
    test_raw_fields(240);
    test_backpressure();

    // nothing owed any more; let the pipeline settle past its latency
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (pending_counts.size() != 0) begin
      report_mismatch($sformatf("%0d day counts never arrived", pending_counts.size()));
    end

    $display("summary: %0d date pairs checked, %0d reversed, %0d saturated",
             n_checked, n_reversed, n_saturated);
    $display("summary: directed edges, well-formed and raw pairs, stalls and a hold-off");
    if (n_errors == 0) begin
      $display("** gregorian_date_difference_top: PASSED **");
    end else begin
      $display("** gregorian_date_difference_top: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("timeout: %0d date pairs sent, %0d checked", n_sent, n_checked);
    $display("** gregorian_date_difference_top: FAILED **");
    $finish;
  end

endmodule
